[rtl/wgss_pkg.sv]
`default_nettype none

package wgss_pkg;

    // Field widths
    localparam int GLOBAL_W = 32;
    localparam int GROUP_W  = 11;
    localparam int MAXG_W   = 16;
    localparam int MULT_W   = 11;
    localparam int CFG_IX_W = 8;
    localparam int CFG_D_W  = 16;
    localparam int OUT_TD_W = 16;

    // Output saturation
    localparam logic [GROUP_W-1:0] OUT_MAX = 11'd2047;

    // Register indexes
    localparam logic [CFG_IX_W-1:0] REG_MAX_GROUP = 8'd0;
    localparam logic [CFG_IX_W-1:0] REG_PREF_MULT = 8'd1;

    // Register reset values
    localparam logic [MAXG_W-1:0] MAXG_RESET = 16'd256;
    localparam logic [MULT_W-1:0] MULT_RESET = 11'd32;

endpackage

`default_nettype wire

[rtl/work_group_size_select_1d.sv]
`default_nettype none
// Each launch doubles the limit at most log2(SIZE_CAP) times (10 by default), then the
// shared 32-step remainder unit tries divisor candidates (none for a zero size, else 1 up
// to the limit, at most the larger of SIZE_CAP and the preferred multiple), and runs once more
// to round for a preferred multiple above one. Throughput: one transaction at a time; the input is
// not ready until the result is registered, and a new result holds until the output drains.
// Reset (synchronous, active low): idle, no result pending, registers 256 and 32.
module work_group_size_select_1d #(
    parameter int SIZE_CAP = 1024
) (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    // slave side, tdata: launch size [31:0]
    input  wire                                i_s_tvalid,
    output logic                               o_s_tready,
    input  wire  [wgss_pkg::GLOBAL_W-1:0]      i_s_tdata,
    // master side, tdata: group_size[10:0], zeros [15:11]
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [wgss_pkg::OUT_TD_W-1:0]      o_m_tdata,
    // configuration write channel
    input  wire                                i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire  [wgss_pkg::CFG_IX_W-1:0]      i_cfg_index,
    input  wire  [wgss_pkg::CFG_D_W-1:0]       i_cfg_data
);
    import wgss_pkg::*;

    // Limit / candidate width: holds the preferred multiple and SIZE_CAP
    localparam int CAP_W = $clog2(SIZE_CAP + 1);
    localparam int LW    = (CAP_W > 12) ? CAP_W : 12;
    localparam int CW    = 32;
    localparam logic [CW-1:0] CAP_C = CW'(SIZE_CAP);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DOUBLE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_ROUND  = 3'd3;
    localparam logic [2:0] S_FINAL  = 3'd4;

    logic [2:0]          r_state, n_state;
    logic                r_out_valid, n_out_valid;
    logic [GROUP_W-1:0]  r_out_data, n_out_data;
    logic [MAXG_W-1:0]   r_maxg;
    logic [MULT_W-1:0]   r_pmult;

    logic [GLOBAL_W-1:0] r_g, n_g;
    logic [MULT_W-1:0]   r_mult, n_mult;
    logic [LW-1:0]       r_limit, n_limit;
    logic [LW-1:0]       r_best, n_best;
    logic [LW-1:0]       r_div_d, n_div_d;
    logic [LW-1:0]       r_rem, n_rem;
    logic [GLOBAL_W-1:0] r_dvd, n_dvd;
    logic [4:0]          r_cnt, n_cnt;
    logic                r_round, n_round;

    // Shared remainder step
    logic [LW:0]   trial;
    logic [LW-1:0] diff;
    logic          ge;
    logic [LW-1:0] rem_nx;
    logic [LW:0]   dbl;
    logic [LW-1:0] cand, mult_ext, rnd_val;
    logic [CW-1:0] fin;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_out_valid;
    assign o_m_tdata   = {{(OUT_TD_W-GROUP_W){1'b0}}, r_out_data};

    always_comb begin
        trial    = {r_rem, r_dvd[GLOBAL_W-1]};
        diff     = trial[LW-1:0] - r_div_d;
        ge       = (trial >= {1'b0, r_div_d});
        rem_nx   = ge ? diff : trial[LW-1:0];
        dbl      = {r_limit, 1'b0};
        mult_ext = {{(LW-MULT_W){1'b0}}, r_mult};
        cand     = (r_g < {{(GLOBAL_W-LW){1'b0}}, r_limit}) ? r_g[LW-1:0] : r_limit;
        rnd_val  = r_best - rem_nx;
        // Final clamp to the maximum, then to one, then to the field
        fin = {{(CW-LW){1'b0}}, r_best};
        if (fin > {{(CW-MAXG_W){1'b0}}, r_maxg}) begin
            fin = {{(CW-MAXG_W){1'b0}}, r_maxg};
        end
        if (fin == '0) begin
            fin = CW'(1);
        end
        if (fin > {{(CW-GROUP_W){1'b0}}, OUT_MAX}) begin
            fin = {{(CW-GROUP_W){1'b0}}, OUT_MAX};
        end
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_g         = r_g;
        n_mult      = r_mult;
        n_limit     = r_limit;
        n_best      = r_best;
        n_div_d     = r_div_d;
        n_rem       = r_rem;
        n_dvd       = r_dvd;
        n_cnt       = r_cnt;
        n_round     = r_round;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_g     = i_s_tdata;
                    n_mult  = (r_pmult == '0) ? MULT_W'(1) : r_pmult;
                    n_limit = {{(LW-MULT_W){1'b0}}, n_mult};
                    n_state = S_DOUBLE;
                end
            end
            S_DOUBLE: begin
                if (({{(CW-LW-1){1'b0}}, dbl} <= {{(CW-MAXG_W){1'b0}}, r_maxg}) &&
                    ({{(CW-LW-1){1'b0}}, dbl} <= CAP_C)) begin
                    n_limit = dbl[LW-1:0];
                end else if (cand == '0) begin
                    // empty launch
                    n_best  = LW'(1);
                    n_state = S_ROUND;
                end else begin
                    n_div_d = cand;
                    n_dvd   = r_g;
                    n_rem   = '0;
                    n_cnt   = 5'd31;
                    n_round = 1'b0;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = rem_nx;
                n_dvd = {r_dvd[GLOBAL_W-2:0], 1'b0};
                n_cnt = r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    if (r_round) begin
                        n_best  = (rnd_val == '0) ? mult_ext : rnd_val;
                        n_state = S_FINAL;
                    end else if (rem_nx == '0) begin
                        n_best  = r_div_d;
                        n_state = S_ROUND;
                    end else begin
                        // next smaller candidate; one always divides
                        n_div_d = r_div_d - LW'(1);
                        n_dvd   = r_g;
                        n_rem   = '0;
                        n_cnt   = 5'd31;
                    end
                end
            end
            S_ROUND: begin
                if (r_mult > MULT_W'(1)) begin
                    n_div_d = mult_ext;
                    n_dvd   = {{(GLOBAL_W-LW){1'b0}}, r_best};
                    n_rem   = '0;
                    n_cnt   = 5'd31;
                    n_round = 1'b1;
                    n_state = S_DIV;
                end else begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_data  = fin[GROUP_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_maxg      <= MAXG_RESET;
            r_pmult     <= MULT_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                if (i_cfg_index == REG_MAX_GROUP) begin
                    r_maxg <= i_cfg_data[MAXG_W-1:0];
                end else if (i_cfg_index == REG_PREF_MULT) begin
                    r_pmult <= i_cfg_data[MULT_W-1:0];
                end
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_out_data <= n_out_data;
        r_g        <= n_g;
        r_mult     <= n_mult;
        r_limit    <= n_limit;
        r_best     <= n_best;
        r_div_d    <= n_div_d;
        r_rem      <= n_rem;
        r_dvd      <= n_dvd;
        r_cnt      <= n_cnt;
        r_round    <= n_round;
    end

    // Divisor is never zero while the remainder unit runs
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_div_d != '0))
        else $error("remainder unit running with zero divisor");

    // Partial remainder stays below the divisor
    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_div_d))
        else $error("partial remainder not below divisor");

    // An accepted transaction starts the doubling phase
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_DOUBLE))
        else $error("accepted transaction did not start");

    // Delivered group size is never zero
    a_out_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[GROUP_W-1:0] != '0))
        else $error("zero group size delivered");

    // Limit never exceeds the cap unless it is the multiple itself
    a_limit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOUBLE) |->
            (({{(CW-LW){1'b0}}, r_limit} <= CAP_C) || (r_limit == mult_ext)))
        else $error("limit above cap");

endmodule

`default_nettype wire

[dv/group_size_check.sv]
`default_nettype none

module group_size_check #(
    parameter int SIZE_CAP = 1024
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    input  wire                              i_s_tready,
    input  wire  [wgss_pkg::GLOBAL_W-1:0]    i_s_tdata,
    input  wire                              i_m_tvalid,
    input  wire                              i_m_tready,
    input  wire  [wgss_pkg::OUT_TD_W-1:0]    i_m_tdata,
    input  wire                              i_cfg_valid,
    input  wire                              i_cfg_ready,
    input  wire  [wgss_pkg::CFG_IX_W-1:0]    i_cfg_index,
    input  wire  [wgss_pkg::CFG_D_W-1:0]     i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import wgss_pkg::*;

    typedef struct packed {
        logic [GLOBAL_W-1:0] launch_size;
        logic [GROUP_W-1:0]  group_size;
    } t_launch_expect;

    t_launch_expect     pending_group_sizes[$];
    logic [MAXG_W-1:0]  max_group;
    logic [MULT_W-1:0]  pref_mult;
    int                 failures_seen = 0;

    assign o_fail_count = failures_seen;

    task automatic report_mismatch(input string what);
        $display("group_size_check: %s", what);
        failures_seen++;
    endtask

    // Grow the limit by doubling, take the largest divisor within it, then round and clamp
    function automatic logic [GROUP_W-1:0] select_group_size(
        input logic [GLOBAL_W-1:0] launch_size,
        input logic [MAXG_W-1:0]   max_g,
        input logic [MULT_W-1:0]   mult_reg
    );
        longint unsigned g;
        longint unsigned maxg;
        longint unsigned mult;
        longint unsigned limit;
        longint unsigned cand;
        longint unsigned best;
        bit              found;
        g     = launch_size;
        maxg  = max_g;
        mult  = (mult_reg == '0) ? 1 : mult_reg;
        limit = mult;
        while (limit * 2 <= maxg && limit * 2 <= SIZE_CAP)
            limit = limit * 2;
        // zero launch size leaves no candidate and falls back to one
        best  = 1;
        found = 1'b0;
        cand  = (g < limit) ? g : limit;
        while (cand >= 1 && !found) begin
            if (g % cand == 0) begin
                best  = cand;
                found = 1'b1;
            end else begin
                cand--;
            end
        end
        if (mult > 1) begin
            best = (best / mult) * mult;
            if (best == 0)
                best = mult;
        end
        if (best > maxg)
            best = maxg;
        if (best < 1)
            best = 1;
        if (best > OUT_MAX)
            best = OUT_MAX;
        return best[GROUP_W-1:0];
    endfunction

    // Track registers, queue predictions on launch, compare on result
    always @(posedge i_clk) begin
        t_launch_expect exp_item;
        if (!i_rst_n) begin
            pending_group_sizes.delete();
            max_group = MAXG_RESET;
            pref_mult = MULT_RESET;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_MAX_GROUP: max_group = i_cfg_data;
                    REG_PREF_MULT: pref_mult = i_cfg_data[MULT_W-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                exp_item.launch_size = i_s_tdata;
                exp_item.group_size  = select_group_size(i_s_tdata, max_group, pref_mult);
                pending_group_sizes.push_back(exp_item);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_group_sizes.size() == 0) begin
                    report_mismatch($sformatf("result %h with no launch pending", i_m_tdata));
                end else begin
                    exp_item = pending_group_sizes.pop_front();
                    if (i_m_tdata[GROUP_W-1:0] !== exp_item.group_size)
                        report_mismatch($sformatf("launch size %0d: group_size %0d, expected %0d",
                            exp_item.launch_size, i_m_tdata[GROUP_W-1:0],
                            exp_item.group_size));
                    if (i_m_tdata[OUT_TD_W-1:GROUP_W] !== '0)
                        report_mismatch($sformatf("launch size %0d: tdata padding %h not zero",
                            exp_item.launch_size, i_m_tdata[OUT_TD_W-1:GROUP_W]));
                end
            end
            o_pending <= pending_group_sizes.size();
        end
    end

endmodule

`default_nettype wire

[dv/testbench.sv]
`default_nettype none

module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import wgss_pkg::*;

    localparam int     SIZE_CAP        = 1024;
    localparam int     RANDOM_PHASES   = 6;
    localparam int     PHASE_LAUNCHES  = 14;
    localparam int     DRAIN_CYCLES    = 100;
    // worst item: 2047 divisor candidates and a rounding pass plus stalls and gaps, ~105 items, x4 margin
    localparam longint CYCLE_LIMIT     = 30_000_000;

    // register indexes that map to nothing
    localparam logic [CFG_IX_W-1:0] REG_UNUSED = REG_PREF_MULT + 1'b1;
    localparam logic [CFG_IX_W-1:0] REG_TOP    = '1;

    typedef enum logic [1:0] {READY_ALWAYS, READY_RANDOM, READY_SPARSE} t_ready_mode;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [GLOBAL_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_TD_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IX_W-1:0]  cfg_index = '0;
    logic [CFG_D_W-1:0]   cfg_data = '0;

    int                   fail_count;
    int                   pending;
    longint               cycles = 0;
    t_ready_mode          ready_mode = READY_ALWAYS;
    int                   ready_hold = 0;
    int                   burst_left = 1;
    logic [MULT_W-1:0]    cur_pref_mult = MULT_RESET;

    work_group_size_select_1d #(
        .SIZE_CAP(SIZE_CAP)
    ) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    group_size_check #(
        .SIZE_CAP(SIZE_CAP)
    ) u_group_size_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result side backpressure: modes of random length
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready   <= 1'b0;
            ready_hold <= 0;
            ready_mode <= READY_ALWAYS;
        end else if (ready_hold == 0) begin
            ready_mode <= t_ready_mode'($urandom_range(0, 2));
            ready_hold <= $urandom_range(16, 400);
            m_tready   <= 1'b1;
        end else begin
            ready_hold <= ready_hold - 1;
            case (ready_mode)
                READY_ALWAYS: m_tready <= 1'b1;
                READY_RANDOM: m_tready <= 1'($urandom_range(0, 1));
                default:      m_tready <= ($urandom_range(0, 7) == 0);
            endcase
        end
    end

    // One launch transaction; tvalid stays high for the rest of the burst
    task automatic send_launch(input logic [GLOBAL_W-1:0] launch_size);
        s_tvalid <= 1'b1;
        s_tdata  <= launch_size;
        do @(posedge clk); while (!s_tready);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
    endtask

    // Wait until every launch has its result back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_IX_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_PREF_MULT)
            cur_pref_mult = data[MULT_W-1:0];
    endtask

    task automatic set_config(input logic [CFG_D_W-1:0] max_data,
                              input logic [CFG_D_W-1:0] mult_data);
        drain();
        write_reg(REG_MAX_GROUP, max_data);
        write_reg(REG_PREF_MULT, mult_data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly sizes with useful divisors, some fully random and some extremes
    function automatic logic [GLOBAL_W-1:0] pick_launch_size();
        int unsigned        d;
        longint unsigned    eff_mult;
        logic [GLOBAL_W-1:0] g;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                d = $urandom_range(1, 1024);
                g = d * $urandom_range(1, 32'hFFFF_FFFF / d);
            end
            4, 5: g = GLOBAL_W'($urandom_range(1, 15)) << $urandom_range(0, 27);
            6: g = $urandom_range(0, 4096);
            7: g = $urandom;
            8: begin
                eff_mult = (cur_pref_mult == '0) ? 1 : cur_pref_mult;
                g = GLOBAL_W'(eff_mult * $urandom_range(1, 1 << 20));
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: g = '0;
                    1: g = 32'd1;
                    2: g = '1;
                    default: g = 32'h8000_0000;
                endcase
            end
        endcase
        return g;
    endfunction

    function automatic logic [CFG_D_W-1:0] pick_max_group();
        case ($urandom_range(0, 3))
            0: return CFG_D_W'($urandom_range(1, 100));
            1: return CFG_D_W'($urandom_range(100, 2048));
            2: return CFG_D_W'($urandom_range(0, 65535));
            default: return (16'h1 << $urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [CFG_D_W-1:0] pick_pref_mult();
        // upper bits are random to show the register keeps only its low 11
        logic [CFG_D_W-1:0] v;
        v = CFG_D_W'($urandom);
        if ($urandom_range(0, 4) != 0)
            v[MULT_W-1:0] = MULT_W'($urandom_range(0, 64));
        else
            v[MULT_W-1:0] = MULT_W'($urandom_range(65, 2047));
        return v;
    endfunction

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        burst_left = $urandom_range(1, 12);

        // reset settings: 256 / 32
        send_launch(32'd0);
        send_launch(32'd1);
        send_launch(32'hFFFF_FFFF);
        send_launch(32'd4294967291);   // largest 32-bit prime
        send_launch(32'd96);

        // widest limit, no rounding
        set_config(16'hFFFF, 16'd1);
        send_launch(32'hFFFF_FFFF);
        send_launch(32'd1021);
        send_launch(32'd3072);
        send_launch(32'h8000_0000);

        // zero maximum and zero multiple
        set_config(16'h0000, 16'h0000);
        send_launch(32'd12);
        send_launch(32'd0);

        // multiple above the maximum
        set_config(16'd1, 16'd1024);
        send_launch(32'd5000);

        // largest multiple, upper data bits dropped by the register
        set_config(16'hFFFF, 16'hFFFF);
        send_launch(32'd6141);
        send_launch(32'd7);

        // multiple equal to the cap
        set_config(16'hFFFF, 16'd1024);
        send_launch(32'd0);
        send_launch(32'd5120);

        // odd maximum and multiple
        set_config(16'd7, 16'd3);
        send_launch(32'd42);
        send_launch(32'd35);

        // writes to unmapped indexes must leave the settings alone
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_TOP, 16'h0001);
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_launch(32'd42);

        // random settings, random launches
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            set_config(pick_max_group(), pick_pref_mult());
            repeat (PHASE_LAUNCHES) send_launch(pick_launch_size());
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
